[src/dpm_pkg.sv]
// Shared types, widths and register map for the differential drive PID mixer.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package dpm_pkg;

    // Field widths
    localparam int ERR_W      = 8;
    localparam int INT_W      = 24;
    localparam int GAIN_W     = 24;
    localparam int DRV_W      = 16;
    localparam int FRAC_BITS  = 8;

    // Derived arithmetic widths (gains enter the multipliers as signed, one bit wider)
    localparam int DELTA_W     = ERR_W + 1;
    localparam int KP_PROD_W   = GAIN_W + 1 + ERR_W;
    localparam int KI_PROD_W   = GAIN_W + 1 + INT_W;
    localparam int KD_PROD_W   = GAIN_W + 1 + DELTA_W;
    localparam int DIFF_ACC_W  = KI_PROD_W + 2;
    localparam int DIFF_W      = DIFF_ACC_W - FRAC_BITS;
    localparam int BASE_ACC_W  = KD_PROD_W + 1;
    localparam int BASE_Q_W    = BASE_ACC_W - FRAC_BITS;
    localparam int BASE_W      = BASE_Q_W + 1;
    localparam int MIX_W       = DIFF_W + 1;
    localparam int TRUNC_BIAS  = 2 ** FRAC_BITS - 1;

    // Stream and bus widths
    localparam int S_TDATA_W   = ((2 * ERR_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * DRV_W + 7) / 8) * 8;
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 5;
    localparam int REG_IDX_W   = 3;
    localparam int PIPE_DEPTH  = 4;

    // Reset values
    localparam logic [GAIN_W-1:0] DIFF_KP_RST     = GAIN_W'(96000);
    localparam logic [GAIN_W-1:0] DIFF_KI_RST     = GAIN_W'(177);
    localparam logic [GAIN_W-1:0] DIFF_KD_RST     = GAIN_W'(192000);
    localparam logic [GAIN_W-1:0] BASE_KP_RST     = GAIN_W'(15104);
    localparam logic [GAIN_W-1:0] BASE_KD_RST     = GAIN_W'(8960);
    localparam logic [DRV_W-1:0]  BASE_OFFSET_RST = DRV_W'(2300);
    localparam logic [DRV_W-1:0]  OUT_MAX_RST     = DRV_W'(7200);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_DIFF_KP     = 3'd0,
        REG_DIFF_KI     = 3'd1,
        REG_DIFF_KD     = 3'd2,
        REG_BASE_KP     = 3'd3,
        REG_BASE_KD     = 3'd4,
        REG_BASE_OFFSET = 3'd5,
        REG_OUT_MAX     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] diff_kp;
        logic [GAIN_W-1:0] diff_ki;
        logic [GAIN_W-1:0] diff_kd;
        logic [GAIN_W-1:0] base_kp;
        logic [GAIN_W-1:0] base_kd;
        logic [DRV_W-1:0]  base_offset;
        logic [DRV_W-1:0]  out_max;
    } cfg_t;

    // Errors, updated integral and deltas of one tick
    typedef struct packed {
        logic signed [ERR_W-1:0]   steer;
        logic signed [ERR_W-1:0]   speed;
        logic signed [INT_W-1:0]   integ;
        logic signed [DELTA_W-1:0] steer_delta;
        logic signed [DELTA_W-1:0] speed_delta;
    } err_beat_t;

    // Gain products of one tick
    typedef struct packed {
        logic signed [KP_PROD_W-1:0] diff_p;
        logic signed [KI_PROD_W-1:0] diff_i;
        logic signed [KD_PROD_W-1:0] diff_d;
        logic signed [KP_PROD_W-1:0] base_p;
        logic signed [KD_PROD_W-1:0] base_d;
    } prod_beat_t;

    // Differential and base terms after scaling
    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic signed [BASE_W-1:0] base;
    } term_beat_t;

endpackage

[src/dpm_cfg_regs.sv]
// APB register file holding the gains, base offset and output limit.
// Depends on dpm_pkg.
`timescale 1ns / 1ps

module dpm_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpm_pkg::PADDR_W-1:0] paddr,
    input  logic [dpm_pkg::PDATA_W-1:0] pwdata,
    output logic [dpm_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output dpm_pkg::cfg_t               cfg
);

    dpm_pkg::cfg_t     cfg_reg;
    dpm_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = dpm_pkg::reg_idx_t'(paddr[dpm_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diff_kp     <= dpm_pkg::DIFF_KP_RST;
            cfg_reg.diff_ki     <= dpm_pkg::DIFF_KI_RST;
            cfg_reg.diff_kd     <= dpm_pkg::DIFF_KD_RST;
            cfg_reg.base_kp     <= dpm_pkg::BASE_KP_RST;
            cfg_reg.base_kd     <= dpm_pkg::BASE_KD_RST;
            cfg_reg.base_offset <= dpm_pkg::BASE_OFFSET_RST;
            cfg_reg.out_max     <= dpm_pkg::OUT_MAX_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                dpm_pkg::REG_DIFF_KP:     cfg_reg.diff_kp     <= pwdata[dpm_pkg::GAIN_W-1:0];
                dpm_pkg::REG_DIFF_KI:     cfg_reg.diff_ki     <= pwdata[dpm_pkg::GAIN_W-1:0];
                dpm_pkg::REG_DIFF_KD:     cfg_reg.diff_kd     <= pwdata[dpm_pkg::GAIN_W-1:0];
                dpm_pkg::REG_BASE_KP:     cfg_reg.base_kp     <= pwdata[dpm_pkg::GAIN_W-1:0];
                dpm_pkg::REG_BASE_KD:     cfg_reg.base_kd     <= pwdata[dpm_pkg::GAIN_W-1:0];
                dpm_pkg::REG_BASE_OFFSET: cfg_reg.base_offset <= pwdata[dpm_pkg::DRV_W-1:0];
                dpm_pkg::REG_OUT_MAX:     cfg_reg.out_max     <= pwdata[dpm_pkg::DRV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            dpm_pkg::REG_DIFF_KP:     prdata = dpm_pkg::PDATA_W'(cfg_reg.diff_kp);
            dpm_pkg::REG_DIFF_KI:     prdata = dpm_pkg::PDATA_W'(cfg_reg.diff_ki);
            dpm_pkg::REG_DIFF_KD:     prdata = dpm_pkg::PDATA_W'(cfg_reg.diff_kd);
            dpm_pkg::REG_BASE_KP:     prdata = dpm_pkg::PDATA_W'(cfg_reg.base_kp);
            dpm_pkg::REG_BASE_KD:     prdata = dpm_pkg::PDATA_W'(cfg_reg.base_kd);
            dpm_pkg::REG_BASE_OFFSET: prdata = dpm_pkg::PDATA_W'(cfg_reg.base_offset);
            dpm_pkg::REG_OUT_MAX:     prdata = dpm_pkg::PDATA_W'(cfg_reg.out_max);
            default:                  prdata = '0;
        endcase
    end

endmodule

[src/dpm_err_stage.sv]
// Input stage: controller state (saturating integral, last errors) and error deltas.
// Depends on dpm_pkg.
`timescale 1ns / 1ps

module dpm_err_stage
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [dpm_pkg::ERR_W-1:0] in_steer,
    input  logic [dpm_pkg::ERR_W-1:0] in_speed,
    output logic                      out_valid,
    input  logic                      out_ready,
    output dpm_pkg::err_beat_t        out_beat
);

    localparam logic signed [dpm_pkg::INT_W-1:0] INT_MAX = {1'b0, {(dpm_pkg::INT_W-1){1'b1}}};
    localparam logic signed [dpm_pkg::INT_W-1:0] INT_MIN = {1'b1, {(dpm_pkg::INT_W-1){1'b0}}};

    logic signed [dpm_pkg::INT_W-1:0] steer_integral_reg, steer_integral_next;
    logic signed [dpm_pkg::ERR_W-1:0] steer_last_reg;
    logic signed [dpm_pkg::ERR_W-1:0] speed_last_reg;
    logic signed [dpm_pkg::INT_W:0]   integ_sum;
    logic                             valid_reg;
    logic                             accept;
    dpm_pkg::err_beat_t               beat_reg, beat_next;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb
    begin
        integ_sum = (dpm_pkg::INT_W+1)'(steer_integral_reg)
                  + (dpm_pkg::INT_W+1)'($signed(in_steer));
        // clip when the two top bits disagree
        if (integ_sum[dpm_pkg::INT_W] != integ_sum[dpm_pkg::INT_W-1])
            steer_integral_next = integ_sum[dpm_pkg::INT_W] ? INT_MIN : INT_MAX;
        else
            steer_integral_next = integ_sum[dpm_pkg::INT_W-1:0];

        beat_next.steer       = in_steer;
        beat_next.speed       = in_speed;
        beat_next.integ       = steer_integral_next;
        beat_next.steer_delta = dpm_pkg::DELTA_W'($signed(in_steer))
                              - dpm_pkg::DELTA_W'(steer_last_reg);
        beat_next.speed_delta = dpm_pkg::DELTA_W'($signed(in_speed))
                              - dpm_pkg::DELTA_W'(speed_last_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg          <= 1'b0;
            steer_integral_reg <= '0;
            steer_last_reg     <= '0;
            speed_last_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                valid_reg <= in_valid;
            if (accept)
            begin
                steer_integral_reg <= steer_integral_next;
                steer_last_reg     <= in_steer;
                speed_last_reg     <= in_speed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            beat_reg <= beat_next;
    end

endmodule

[src/dpm_mult_stage.sv]
// Multiply stage: the five gain products, one multiplier each, registered.
// Depends on dpm_pkg.
`timescale 1ns / 1ps

module dpm_mult_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  dpm_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  dpm_pkg::err_beat_t in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output dpm_pkg::prod_beat_t out_beat
);

    logic                valid_reg;
    dpm_pkg::prod_beat_t beat_reg, beat_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb
    begin
        beat_next.diff_p = dpm_pkg::KP_PROD_W'($signed({1'b0, cfg.diff_kp}))
                         * dpm_pkg::KP_PROD_W'(in_beat.steer);
        beat_next.diff_i = dpm_pkg::KI_PROD_W'($signed({1'b0, cfg.diff_ki}))
                         * dpm_pkg::KI_PROD_W'(in_beat.integ);
        beat_next.diff_d = dpm_pkg::KD_PROD_W'($signed({1'b0, cfg.diff_kd}))
                         * dpm_pkg::KD_PROD_W'(in_beat.steer_delta);
        beat_next.base_p = dpm_pkg::KP_PROD_W'($signed({1'b0, cfg.base_kp}))
                         * dpm_pkg::KP_PROD_W'(in_beat.speed);
        beat_next.base_d = dpm_pkg::KD_PROD_W'($signed({1'b0, cfg.base_kd}))
                         * dpm_pkg::KD_PROD_W'(in_beat.speed_delta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            beat_reg <= beat_next;
    end

endmodule

[src/dpm_sum_stage.sv]
// Sum stage: PID and PD sums, truncating divide by 256, base offset added.
// Depends on dpm_pkg.
`timescale 1ns / 1ps

module dpm_sum_stage
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [dpm_pkg::DRV_W-1:0] base_offset,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  dpm_pkg::prod_beat_t       in_beat,
    output logic                      out_valid,
    input  logic                      out_ready,
    output dpm_pkg::term_beat_t       out_beat
);

    logic signed [dpm_pkg::DIFF_ACC_W-1:0] diff_acc, diff_rnd;
    logic signed [dpm_pkg::BASE_ACC_W-1:0] base_acc, base_rnd;
    logic signed [dpm_pkg::BASE_Q_W-1:0]   base_q;
    logic                                  valid_reg;
    dpm_pkg::term_beat_t                   beat_reg, beat_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb
    begin
        diff_acc = dpm_pkg::DIFF_ACC_W'(in_beat.diff_p)
                 + dpm_pkg::DIFF_ACC_W'(in_beat.diff_i)
                 + dpm_pkg::DIFF_ACC_W'(in_beat.diff_d);
        // bias negatives so the shift rounds toward zero
        diff_rnd = diff_acc + (diff_acc[dpm_pkg::DIFF_ACC_W-1]
                 ? dpm_pkg::DIFF_ACC_W'(dpm_pkg::TRUNC_BIAS) : '0);

        base_acc = dpm_pkg::BASE_ACC_W'(in_beat.base_d)
                 - dpm_pkg::BASE_ACC_W'(in_beat.base_p);
        base_rnd = base_acc + (base_acc[dpm_pkg::BASE_ACC_W-1]
                 ? dpm_pkg::BASE_ACC_W'(dpm_pkg::TRUNC_BIAS) : '0);
        base_q   = base_rnd[dpm_pkg::BASE_ACC_W-1:dpm_pkg::FRAC_BITS];

        beat_next.diff = diff_rnd[dpm_pkg::DIFF_ACC_W-1:dpm_pkg::FRAC_BITS];
        beat_next.base = dpm_pkg::BASE_W'(base_q)
                       + dpm_pkg::BASE_W'($signed({1'b0, base_offset}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            beat_reg <= beat_next;
    end

endmodule

[src/dpm_mix_stage.sv]
// Mix stage: left = base + diff, right = base - diff, clamped to 0..out_max.
// Holds the output register. Depends on dpm_pkg.
`timescale 1ns / 1ps

module dpm_mix_stage
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [dpm_pkg::DRV_W-1:0] out_max,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  dpm_pkg::term_beat_t       in_beat,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [dpm_pkg::DRV_W-1:0] left_drive,
    output logic [dpm_pkg::DRV_W-1:0] right_drive
);

    function automatic logic [dpm_pkg::DRV_W-1:0] clamp_drive
    (
        input logic signed [dpm_pkg::MIX_W-1:0] v,
        input logic [dpm_pkg::DRV_W-1:0]        lim
    );
        logic [dpm_pkg::DRV_W-1:0] res;
        if (v[dpm_pkg::MIX_W-1])
            res = '0;
        else if ((|v[dpm_pkg::MIX_W-2:dpm_pkg::DRV_W]) || (v[dpm_pkg::DRV_W-1:0] > lim))
            res = lim;
        else
            res = v[dpm_pkg::DRV_W-1:0];
        return res;
    endfunction

    logic signed [dpm_pkg::MIX_W-1:0] left_sum, right_sum;
    logic                             valid_reg;
    logic [dpm_pkg::DRV_W-1:0]        left_reg, right_reg;

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;

    assign left_sum  = dpm_pkg::MIX_W'(in_beat.base) + dpm_pkg::MIX_W'(in_beat.diff);
    assign right_sum = dpm_pkg::MIX_W'(in_beat.base) - dpm_pkg::MIX_W'(in_beat.diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            left_reg  <= clamp_drive(left_sum, out_max);
            right_reg <= clamp_drive(right_sum, out_max);
        end
    end

endmodule

[src/differential_drive_pid_mixer.sv]
// Differential drive PID mixer: steering PID plus speed PD, mixed into two wheel drives.
// A beat moves through four register stages (input/state, multiply, sum, mix/output), each of
// which holds one beat, so a new beat is taken every clock while the output is not stalled.
// A result is presented once its beat reaches the mix/output register and can leave when the
// output side is not stalled. One beat per cycle holds because every stage reloads in the
// same cycle its beat moves on; back pressure stalls only the stages that are full. The
// controller state (integral, last errors) is updated as each input beat is accepted. Gains
// are unsigned Q16.8; each PID sum is divided by 256 with truncation toward zero; the
// integral saturates at its signed 24-bit limits. The user must write registers over APB
// only while the block is idle; the block does not enforce this. There is no clearing pass.
// Depends on dpm_pkg and the dpm_* stage modules.
`timescale 1ns / 1ps

module differential_drive_pid_mixer
(
    input  logic                          clk,
    input  logic                          rst_n,

    // Input beats
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [dpm_pkg::S_TDATA_W-1:0] s_axis_tdata,  // steering_error, speed_error

    // Result beats
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [dpm_pkg::M_TDATA_W-1:0] m_axis_tdata,  // left_drive, right_drive

    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dpm_pkg::PADDR_W-1:0]   paddr,
    input  logic [dpm_pkg::PDATA_W-1:0]   pwdata,
    output logic [dpm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    dpm_pkg::cfg_t       cfg;
    dpm_pkg::err_beat_t  err_beat;
    dpm_pkg::prod_beat_t prod_beat;
    dpm_pkg::term_beat_t term_beat;
    logic                err_valid, err_ready;
    logic                prod_valid, prod_ready;
    logic                term_valid, term_ready;
    logic [dpm_pkg::DRV_W-1:0] left_drive, right_drive;

    dpm_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Stage 1: state update and deltas
    dpm_err_stage u_err
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_steer  (s_axis_tdata[dpm_pkg::ERR_W-1:0]),
        .in_speed  (s_axis_tdata[2*dpm_pkg::ERR_W-1:dpm_pkg::ERR_W]),
        .out_valid (err_valid),
        .out_ready (err_ready),
        .out_beat  (err_beat)
    );

    // Stage 2: gain products
    dpm_mult_stage u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (err_valid),
        .in_ready  (err_ready),
        .in_beat   (err_beat),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_beat  (prod_beat)
    );

    // Stage 3: sums, truncation, base offset
    dpm_sum_stage u_sum
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .base_offset (cfg.base_offset),
        .in_valid    (prod_valid),
        .in_ready    (prod_ready),
        .in_beat     (prod_beat),
        .out_valid   (term_valid),
        .out_ready   (term_ready),
        .out_beat    (term_beat)
    );

    // Stage 4: mix, clamp, output register
    dpm_mix_stage u_mix
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .out_max     (cfg.out_max),
        .in_valid    (term_valid),
        .in_ready    (term_ready),
        .in_beat     (term_beat),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .left_drive  (left_drive),
        .right_drive (right_drive)
    );

    assign m_axis_tdata = dpm_pkg::M_TDATA_W'({right_drive, left_drive});

endmodule

[src/dpm_checker.sv]
// Port-level checker for the mixer: beat accounting against pipeline depth, output hold.
// Depends on dpm_pkg; bound to differential_drive_pid_mixer at the end of this file.
`timescale 1ns / 1ps

module dpm_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [dpm_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(dpm_pkg::PIPE_DEPTH + 2);

    logic [CNT_W-1:0] pending_reg, pending_next;
    logic             in_acc, out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
            pending_next = pending_reg + CNT_W'(1);
        else if (!in_acc && out_acc)
            pending_next = pending_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // no result without an accepted input
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != '0)
        else $error("result beat without pending input");

    // never more beats in flight than stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(dpm_pkg::PIPE_DEPTH))
        else $error("more beats in flight than pipeline stages");

    // empty pipeline always takes a beat
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == '0 |-> s_axis_tready)
        else $error("input stalled with empty pipeline");

endmodule

bind differential_drive_pid_mixer dpm_checker u_dpm_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
